// ----- hw/rtl/dreg_pkg.sv -----
// Types, constants and address decode functions for the display register block.
package dreg_pkg;

  localparam int unsigned OffW   = 20;
  localparam int unsigned DataW  = 32;
  localparam int unsigned SlotN  = 14;
  localparam int unsigned SlotW  = $clog2(SlotN);
  localparam int unsigned SpanN  = 71;

  localparam logic [DataW-1:0] VersionWord = 32'h0400_0000;
  localparam logic [OffW-1:0]  OffVersion  = 20'h00000;
  localparam logic [OffW-1:0]  OffEnable   = 20'h00050;
  localparam logic [OffW-1:0]  OffStatus   = 20'h00054;
  localparam logic [OffW-1:0]  OffClear    = 20'h00058;
  localparam logic [OffW-1:0]  OffKickA    = 20'h00004;
  localparam logic [OffW-1:0]  OffKickB    = 20'h00010;
  localparam logic [DataW-1:0] BitKickA    = 32'h0000_0001;
  localparam logic [DataW-1:0] BitKickB    = 32'h0000_0004;

  typedef enum logic [1:0] {
    AccOk    = 2'd0,
    AccRdErr = 2'd1,
    AccWrErr = 2'd2
  } acc_status_e;

  typedef enum logic {
    ReqRead  = 1'b0,
    ReqWrite = 1'b1
  } req_type_e;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] idx;
  } slot_hit_t;

  // Readable registers backed by the word memory (enable and status live in flops).
  localparam logic [OffW-1:0] SlotOff [SlotN] = '{
    20'h00018, 20'h00038, 20'h90000, 20'hA0000, 20'h00124, 20'hC0000, 20'h00070,
    20'h00100, 20'h00104, 20'h0020C, 20'h10014, 20'h18014, 20'h10100, 20'h50058
  };

  localparam logic [OffW-1:0] SpanLo [SpanN] = '{
    20'h00028, 20'h00030, 20'h00038, 20'h00048, 20'h00060, 20'h00068, 20'h00070,
    20'h00090, 20'h00094, 20'h00098, 20'h00100, 20'h00104, 20'h00118, 20'h0011C,
    20'h00124, 20'h00200, 20'h00204, 20'h0020C, 20'h00210, 20'h00214, 20'h0021C,
    20'h00220, 20'h10004, 20'h10008, 20'h10014, 20'h18014, 20'h10100, 20'h18000,
    20'h50000, 20'h50010, 20'h50040, 20'h50050, 20'h11004, 20'h21004, 20'h31004,
    20'h41004, 20'h51004, 20'h91004, 20'h24400, 20'h24500, 20'h24580, 20'h24600,
    20'h24680, 20'h28100, 20'h28200, 20'h29000, 20'h34400, 20'h34500, 20'h34580,
    20'h34600, 20'h34680, 20'h38100, 20'h38200, 20'h39000, 20'h90000, 20'h90018,
    20'h90040, 20'h90060, 20'hA0000, 20'hA0018, 20'h93400, 20'h93500, 20'h93580,
    20'h93600, 20'h93680, 20'h94800, 20'h95004, 20'h95010, 20'h95018, 20'hC0000,
    20'hC2000
  };

  localparam logic [OffW-1:0] SpanHi [SpanN] = '{
    20'h00028, 20'h00030, 20'h00038, 20'h00048, 20'h00060, 20'h00068, 20'h00070,
    20'h00090, 20'h00094, 20'h00098, 20'h00100, 20'h00104, 20'h00118, 20'h0011C,
    20'h00124, 20'h00200, 20'h00204, 20'h0020C, 20'h00210, 20'h00214, 20'h0021C,
    20'h00220, 20'h10004, 20'h10010, 20'h10014, 20'h18014, 20'h10100, 20'h18000,
    20'h5000C, 20'h50010, 20'h50040, 20'h50060, 20'h11004, 20'h21004, 20'h31004,
    20'h41004, 20'h51004, 20'h91004, 20'h24420, 20'h24508, 20'h24588, 20'h24614,
    20'h24694, 20'h2810C, 20'h28204, 20'h2AFFC, 20'h34420, 20'h34508, 20'h34588,
    20'h34614, 20'h34694, 20'h3810C, 20'h38204, 20'h3AFFC, 20'h90010, 20'h90020,
    20'h9004C, 20'h90070, 20'hA0010, 20'hA0018, 20'h93420, 20'h93508, 20'h93588,
    20'h93614, 20'h93694, 20'h94FFC, 20'h95008, 20'h95010, 20'h9501C, 20'hC0038,
    20'hC2010
  };

  // Exact offset match against the memory-backed readable registers.
  function automatic slot_hit_t read_slot(input logic [OffW-1:0] off);
    slot_hit_t r;
    r = '0;
    for (int i = 0; i < SlotN; i++) begin
      if (off == SlotOff[i]) begin
        r.hit = 1'b1;
        r.idx = SlotW'(i);
      end
    end
    return r;
  endfunction

  // Word match: unaligned stores land on word off/4.
  function automatic slot_hit_t write_slot(input logic [OffW-1:0] off);
    slot_hit_t r;
    r = '0;
    for (int i = 0; i < SlotN; i++) begin
      if (off[OffW-1:2] == SlotOff[i][OffW-1:2]) begin
        r.hit = 1'b1;
        r.idx = SlotW'(i);
      end
    end
    return r;
  endfunction

  function automatic logic is_writable(input logic [OffW-1:0] off);
    logic w;
    w = 1'b0;
    for (int i = 0; i < SpanN; i++) begin
      if (off >= SpanLo[i] && off <= SpanHi[i]) w = 1'b1;
    end
    return w;
  endfunction

endpackage

// ----- hw/rtl/dreg_if.sv -----
// Request and response channel interfaces of the display register block.
interface dreg_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [19:0] byte_offset;
  logic [31:0] write_data;

  modport source (output valid, req_type, byte_offset, write_data, input ready);
  modport sink   (input valid, req_type, byte_offset, write_data, output ready);
endinterface

interface dreg_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_line;
  logic [1:0]  access_status;

  modport source (output valid, read_data, irq_line, access_status, input ready);
  modport sink   (input valid, read_data, irq_line, access_status, output ready);
endinterface

// ----- hw/rtl/display_engine_register_block_unit.sv -----
// Display engine register block: bus request decode, register memory and interrupt line.
// Each request is a read or write at a byte offset of the 1 MiB window and yields exactly
// one response in the next cycle, held in an output register; a new request is taken every
// cycle as long as that register is empty or being drained, so the block sustains one
// request per clock, set by the single port of the register memory (one read or one write
// per cycle). The readable data registers sit in a 14-word synchronous memory with
// per-word valid bits that reset clears at once, so no clearing pass is needed; words that
// can never be read back are not stored. The interrupt enable and status words are kept in
// flops because every response reports the interrupt line. Offset 0 returns the version
// word. Writes to the clear word drop status bits, the two kick offsets set status bit 0
// or 2, and other writes are stored only inside the writable spans (unaligned ones land on
// offset/4). An unsupported access returns zero data with an error code and changes
// nothing.
module display_engine_register_block_unit (
  input  logic   clk_i,
  input  logic   rst_ni,
  dreg_req_if.sink   req_i,
  dreg_rsp_if.source rsp_o
);
  import dreg_pkg::*;

  // register memory
  logic [DataW-1:0] mem [SlotN];
  logic [DataW-1:0] mem_rdata_q;
  logic [SlotN-1:0] vld_q, vld_d;
  logic             mem_we, mem_re;
  logic [SlotW-1:0] mem_idx;

  // interrupt words
  logic [DataW-1:0] en_q, en_d, st_q, st_d;

  // response register
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] rdata_q, rdata_d;
  logic             sel_mem_q, sel_mem_d;
  logic             rd_vld_q;
  logic             irq_q;
  acc_status_e      status_q, status_d;

  logic             acc;
  slot_hit_t        rd_hit, wr_hit;
  logic [OffW-1:0]  off;
  logic [DataW-1:0] wdata;

  assign off   = req_i.byte_offset;
  assign wdata = req_i.write_data;

  // one request in flight at most: output register frees up as it drains
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  assign rd_hit = read_slot(off);
  assign wr_hit = write_slot(off);

  // decode and state update
  always_comb begin
    en_d      = en_q;
    st_d      = st_q;
    vld_d     = vld_q;
    status_d  = AccOk;
    rdata_d   = '0;
    sel_mem_d = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_idx   = (req_i.req_type == ReqWrite) ? wr_hit.idx : rd_hit.idx;
    if (acc) begin
      if (req_i.req_type == ReqRead) begin
        if (off == OffVersion) begin
          rdata_d = VersionWord;
        end else if (off == OffEnable) begin
          rdata_d = en_q;
        end else if (off == OffStatus) begin
          rdata_d = st_q;
        end else if (rd_hit.hit) begin
          mem_re    = 1'b1;
          sel_mem_d = 1'b1;
        end else begin
          status_d = AccRdErr;
        end
      end else if (off == OffEnable) begin
        en_d = wdata;
      end else if (off == OffClear) begin
        st_d = st_q & ~wdata;
      end else if (off == OffKickA) begin
        st_d = st_q | BitKickA;
      end else if (off == OffKickB) begin
        st_d = st_q | BitKickB;
      end else if (is_writable(off)) begin
        // stores that no readable word shares are not observable
        if (wr_hit.hit) begin
          mem_we         = 1'b1;
          vld_d[mem_idx] = 1'b1;
        end
      end else begin
        status_d = AccWrErr;
      end
    end
  end

  assign out_valid_d = acc || (out_valid_q && !rsp_o.ready);

  // single-port memory: one read or one write per cycle; a write is visible to the
  // next request's read, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_idx] <= wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rdata_q   <= rdata_d;
      sel_mem_q <= sel_mem_d;
      rd_vld_q  <= vld_q[mem_idx];
      status_q  <= status_d;
      irq_q     <= |(st_d & en_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      en_q        <= '0;
      st_q        <= '0;
      vld_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      en_q        <= en_d;
      st_q        <= st_d;
      vld_q       <= vld_d;
    end
  end

  // response: never-written words read as zero
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_data     = sel_mem_q ? (rd_vld_q ? mem_rdata_q : '0) : rdata_q;
  assign rsp_o.irq_line      = irq_q;
  assign rsp_o.access_status = status_q;

  // assertions
  a_irq_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (irq_q == |(st_q & en_q)))
    else $error("irq_line does not match status and enable");

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != AccOk) |-> (rsp_o.read_data == '0))
    else $error("error response carries data");

  a_err_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && status_d != AccOk) |=> (en_q == $past(en_q) && st_q == $past(st_q)
                                    && vld_q == $past(vld_q)))
    else $error("unsupported access changed state");

  a_no_mem_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write in one cycle");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_o.ready) |-> !acc)
    else $error("request taken while response stalled");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the display engine register block: random bus requests vs predictor.
module tb_top;
  import dreg_pkg::*;

  // Bus requests as queued by the stimulus and predicted responses.
  typedef struct {
    req_type_e   kind;
    logic [19:0] offset;
    logic [31:0] data;
    bit          drain_first;  // wait for all responses before offering this request
  } access_t;

  typedef struct {
    logic [31:0] rdata;
    logic        irq;
    acc_status_e status;
  } reply_t;

  localparam int RandomCount   = 1350;
  localparam int CalmTail      = 150;     // last requests run without idling
  localparam int LongHoldAt    = 400;     // response count that starts the long hold-off
  localparam int LongHoldLen   = 240;
  localparam int CycleLimit    = 200000;
  localparam int TailCycles    = 8;
  localparam int ShownMax      = 10;
  localparam int ReadableCount = 16;
  localparam int SpanCount     = 71;

  localparam logic [17:0] EnableIdx = OffEnable[19:2];
  localparam logic [17:0] StatusIdx = OffStatus[19:2];

  // Offsets that read back their word, version offset excluded.
  localparam logic [19:0] ReadableOffs [ReadableCount] = '{
    20'h00050, 20'h00054, 20'h00018, 20'h00038, 20'h90000, 20'hA0000,
    20'h00124, 20'hC0000, 20'h00070, 20'h00100, 20'h00104, 20'h0020C,
    20'h10014, 20'h18014, 20'h10100, 20'h50058
  };

  // Writable spans, {low, high} inclusive, five hex digits each.
  localparam logic [39:0] WritableSpans [SpanCount] = '{
    40'h00028_00028, 40'h00030_00030, 40'h00038_00038, 40'h00048_00048,
    40'h00060_00060, 40'h00068_00068, 40'h00070_00070, 40'h00090_00090,
    40'h00094_00094, 40'h00098_00098, 40'h00100_00100, 40'h00104_00104,
    40'h00118_00118, 40'h0011C_0011C, 40'h00124_00124, 40'h00200_00200,
    40'h00204_00204, 40'h0020C_0020C, 40'h00210_00210, 40'h00214_00214,
    40'h0021C_0021C, 40'h00220_00220, 40'h10004_10004, 40'h10008_10010,
    40'h10014_10014, 40'h18014_18014, 40'h10100_10100, 40'h18000_18000,
    40'h50000_5000C, 40'h50010_50010, 40'h50040_50040, 40'h50050_50060,
    40'h11004_11004, 40'h21004_21004, 40'h31004_31004, 40'h41004_41004,
    40'h51004_51004, 40'h91004_91004, 40'h24400_24420, 40'h24500_24508,
    40'h24580_24588, 40'h24600_24614, 40'h24680_24694, 40'h28100_2810C,
    40'h28200_28204, 40'h29000_2AFFC, 40'h34400_34420, 40'h34500_34508,
    40'h34580_34588, 40'h34600_34614, 40'h34680_34694, 40'h38100_3810C,
    40'h38200_38204, 40'h39000_3AFFC, 40'h90000_90010, 40'h90018_90020,
    40'h90040_9004C, 40'h90060_90070, 40'hA0000_A0010, 40'hA0018_A0018,
    40'h93400_93420, 40'h93500_93508, 40'h93580_93588, 40'h93600_93614,
    40'h93680_93694, 40'h94800_94FFC, 40'h95004_95008, 40'h95010_95010,
    40'h95018_9501C, 40'hC0000_C0038, 40'hC2000_C2010
  };

  logic clk_i;
  logic rst_ni;

  dreg_req_if req_bus ();
  dreg_rsp_if rsp_bus ();

  display_engine_register_block_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Predictor state: sparse word store, missing words read as zero.
  logic [31:0] reg_words [bit [17:0]];

  access_t pending_access [$];
  reply_t  expected_reply [$];

  access_t cur_access;
  bit      cur_busy;
  bit      req_taken;       // set at the rising edge that accepted cur_access
  int      send_gap;
  int      sink_gap;
  int      long_hold;
  bit      long_hold_done;
  int      replies_seen;
  int      mismatch_count;
  int      cycle_count;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [31:0] word_at(input logic [17:0] idx);
    return reg_words.exists(idx) ? reg_words[idx] : 32'h0;
  endfunction

  function automatic bit offset_readable(input logic [19:0] off);
    bit hit;
    hit = 1'b0;
    foreach (ReadableOffs[i]) if (ReadableOffs[i] == off) hit = 1'b1;
    return hit;
  endfunction

  function automatic bit offset_writable(input logic [19:0] off);
    bit hit;
    hit = 1'b0;
    foreach (WritableSpans[i])
      if (off >= WritableSpans[i][39:20] && off <= WritableSpans[i][19:0]) hit = 1'b1;
    return hit;
  endfunction

  // Applies one request to the predictor state and returns the response it owes.
  function automatic reply_t predict_access(input access_t a);
    reply_t r;
    r.rdata  = 32'h0;
    r.status = AccOk;
    if (a.kind == ReqRead) begin
      if (a.offset == OffVersion) r.rdata = VersionWord;
      else if (offset_readable(a.offset)) r.rdata = word_at(a.offset[19:2]);
      else r.status = AccRdErr;
    end else if (a.offset == OffEnable) begin
      reg_words[EnableIdx] = a.data;
    end else if (a.offset == OffClear) begin
      reg_words[StatusIdx] = word_at(StatusIdx) & ~a.data;
    end else if (a.offset == OffKickA) begin
      reg_words[StatusIdx] = word_at(StatusIdx) | BitKickA;
    end else if (a.offset == OffKickB) begin
      reg_words[StatusIdx] = word_at(StatusIdx) | BitKickB;
    end else if (offset_writable(a.offset)) begin
      reg_words[a.offset[19:2]] = a.data;  // unaligned stores hit word off/4
    end else begin
      r.status = AccWrErr;
    end
    r.irq = |(word_at(StatusIdx) & word_at(EnableIdx));
    return r;
  endfunction

  task automatic queue_access(input req_type_e kind, input logic [19:0] off,
                              input logic [31:0] data);
    access_t a;
    a.kind        = kind;
    a.offset      = off;
    a.data        = data;
    a.drain_first = 1'b0;
    pending_access.push_back(a);
  endtask

  // One random request; weighted toward offsets that do something.
  function automatic access_t random_access();
    access_t     a;
    logic [39:0] span;
    int          pick;
    pick          = $urandom_range(0, 99);
    a.kind        = ReqWrite;
    a.offset      = 20'($urandom);
    a.data        = $urandom;
    a.drain_first = 1'b0;
    if (pick < 30) begin
      a.kind   = ReqRead;
      a.offset = ReadableOffs[$urandom_range(0, ReadableCount - 1)];
    end else if (pick < 34) begin
      a.kind   = ReqRead;
      a.offset = OffVersion;
    end else if (pick < 40) begin
      // mostly unsupported, some unaligned near a listed offset
      a.kind = ReqRead;
      if ($urandom_range(0, 1) == 0)
        a.offset = ReadableOffs[$urandom_range(0, ReadableCount - 1)]
                   + 20'($urandom_range(1, 3));
    end else if (pick < 50) begin
      a.offset = OffEnable;
      case ($urandom_range(0, 3))
        0: a.data = 32'h0;
        1: a.data = 32'($urandom_range(0, 15));
        default: ;
      endcase
    end else if (pick < 60) begin
      a.offset = ($urandom_range(0, 1) == 0) ? OffKickA : OffKickB;
    end else if (pick < 68) begin
      a.offset = OffClear;
      case ($urandom_range(0, 3))
        0: a.data = BitKickA;
        1: a.data = BitKickB;
        2: a.data = 32'h1 << $urandom_range(0, 31);
        default: ;
      endcase
    end else if (pick < 80) begin
      // write to a readable word, sometimes unaligned
      a.offset = ReadableOffs[$urandom_range(0, ReadableCount - 1)];
      if ($urandom_range(0, 3) == 0) a.offset = a.offset + 20'($urandom_range(1, 3));
    end else if (pick < 94) begin
      span     = WritableSpans[$urandom_range(0, SpanCount - 1)];
      a.offset = span[39:20] + 20'($urandom_range(0, span[19:0] - span[39:20]));
      if ($urandom_range(0, 7) == 0) a.offset = span[19:0] + 20'($urandom_range(1, 3));
    end else if (pick < 97) begin
      a.offset = ($urandom_range(0, 1) == 0) ? OffStatus : OffVersion;
    end
    // remaining picks: fully random write
    return a;
  endfunction

  // Monitor: response check and request acceptance, both at the rising edge.
  always @(posedge clk_i) begin : monitor
    reply_t exp;
    cycle_count++;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        replies_seen++;
        if (expected_reply.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ShownMax)
            $display("response %0d with nothing pending: rdata=%h irq=%b st=%0d",
                     replies_seen, rsp_bus.read_data, rsp_bus.irq_line,
                     rsp_bus.access_status);
        end else begin
          exp = expected_reply.pop_front();
          if (rsp_bus.read_data !== exp.rdata || rsp_bus.irq_line !== exp.irq ||
              rsp_bus.access_status !== exp.status) begin
            mismatch_count++;
            if (mismatch_count <= ShownMax)
              $display("response %0d: exp rdata=%h irq=%b st=%0d, got rdata=%h irq=%b st=%0d",
                       replies_seen, exp.rdata, exp.irq, exp.status,
                       rsp_bus.read_data, rsp_bus.irq_line, rsp_bus.access_status);
          end
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        expected_reply.push_back(predict_access(cur_access));
        req_taken = 1'b1;
      end
    end
  end

  // Request driver: holds a request until taken, random idle bursts between requests.
  always @(negedge clk_i) begin : driver
    bit calm;
    if (rst_ni) begin
      calm = pending_access.size() < CalmTail;
      if (req_taken) begin
        req_taken = 1'b0;
        cur_busy  = 1'b0;
      end
      if (!cur_busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_access.size() != 0) begin
          if (pending_access[0].drain_first && expected_reply.size() != 0) begin
            // pause until every response is back
          end else if (!calm && (cycle_count / 128) % 4 != 3 &&
                       $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 16);
          end else begin
            cur_access = pending_access.pop_front();
            cur_busy   = 1'b1;
          end
        end
      end
      req_bus.valid <= cur_busy;
      if (cur_busy) begin
        req_bus.req_type    <= cur_access.kind;
        req_bus.byte_offset <= cur_access.offset;
        req_bus.write_data  <= cur_access.data;
      end else begin
        req_bus.req_type    <= 1'($urandom_range(0, 1));
        req_bus.byte_offset <= 20'($urandom);
        req_bus.write_data  <= $urandom;
      end
    end
  end

  // Response sink: one long hold-off to back the block up, plus random stall bursts.
  always @(negedge clk_i) begin : sink
    logic rdy;
    if (rst_ni) begin
      if (long_hold > 0) begin
        long_hold--;
        rdy = 1'b0;
      end else if (!long_hold_done && replies_seen >= LongHoldAt) begin
        long_hold_done = 1'b1;
        long_hold      = LongHoldLen - 1;
        rdy            = 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rdy = 1'b0;
      end else if (pending_access.size() >= CalmTail && (cycle_count / 128) % 4 != 3 &&
                   $urandom_range(0, 7) == 0) begin
        sink_gap = $urandom_range(0, 16);
        rdy      = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rsp_bus.ready <= rdy;
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = 1'b0;
    req_bus.byte_offset = '0;
    req_bus.write_data  = '0;
    rsp_bus.ready       = 1'b0;

    // Directed: version, reset values, kicks and clear, error offsets,
    // unaligned stores landing on a readable word.
    queue_access(ReqRead,  OffVersion, 32'h0);
    queue_access(ReqRead,  OffEnable,  32'h0);
    queue_access(ReqRead,  OffStatus,  32'hFFFF_FFFF);
    queue_access(ReqWrite, OffEnable,  32'hFFFF_FFFF);
    queue_access(ReqWrite, OffKickA,   32'hFFFF_FFFF);
    queue_access(ReqWrite, OffKickB,   32'h0);
    queue_access(ReqRead,  OffStatus,  32'h0);
    queue_access(ReqWrite, OffClear,   BitKickA);
    queue_access(ReqRead,  OffStatus,  32'h0);
    queue_access(ReqWrite, OffStatus,  32'hFFFF_FFFF);
    queue_access(ReqWrite, OffVersion, 32'hFFFF_FFFF);
    queue_access(ReqRead,  20'hFFFFC,  32'h0);
    queue_access(ReqWrite, 20'hFFFFF,  32'hFFFF_FFFF);
    queue_access(ReqWrite, 20'h90000,  32'hFFFF_FFFF);
    queue_access(ReqRead,  20'h90000,  32'h0);
    queue_access(ReqWrite, 20'h90003,  32'h0);
    queue_access(ReqRead,  20'h90000,  32'h0);
    queue_access(ReqRead,  20'h90001,  32'h0);
    queue_access(ReqWrite, 20'h50059,  32'hA5A5_5A5A);
    queue_access(ReqRead,  20'h50058,  32'h0);
    queue_access(ReqRead,  20'h00018,  32'h0);
    queue_access(ReqWrite, OffClear,   32'hFFFF_FFFF);
    queue_access(ReqWrite, OffEnable,  32'h0);
    queue_access(ReqRead,  OffStatus,  32'h0);

    for (int i = 0; i < RandomCount; i++) begin
      pending_access.push_back(random_access());
      if (i == 500 || i == 1000) pending_access[pending_access.size() - 1].drain_first = 1'b1;
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_access.size() != 0 || cur_busy || expected_reply.size() != 0)
      @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (mismatch_count == 0 && expected_reply.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/dreg_pkg.sv
hw/rtl/dreg_if.sv
hw/rtl/display_engine_register_block_unit.sv
bench/tb_top.sv
